>>> hdl/cha_pkg.sv
// Shared constants and helpers for the contention hysteresis mode allocator.
package cha_pkg;

  localparam int RATIO_W  = 24;
  localparam int DIV_NW   = 48;
  localparam int DIV_DW   = 32;
  localparam int IN_DW    = 72;
  localparam int OUT_DW   = 64;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 24;
  localparam int MAX_TYPES = 5;

  localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFFFFFF;

  // input kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_EVAL   = 2'd1;
  localparam logic [1:0] KIND_PHASE  = 2'd2;
  localparam logic [1:0] KIND_FORCE  = 2'd3;

  // modes
  localparam logic [1:0] AM_SHARED    = 2'd0;
  localparam logic [1:0] AM_DEDICATED = 2'd1;
  localparam logic [1:0] AM_HYBRID    = 2'd2;

  // phases
  localparam logic [2:0] PH_LAUNCH    = 3'd0;
  localparam logic [2:0] PH_ORBIT     = 3'd1;
  localparam logic [2:0] PH_CRUISE    = 3'd2;
  localparam logic [2:0] PH_SCIENCE   = 3'd3;
  localparam logic [2:0] PH_EMERGENCY = 3'd4;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ACTIVE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MARGIN    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ADAPTIVE  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_OVERHEAD  = 3'd4;

  // overhead * 10 must stay below one (Q0.16) to allow a return to shared
  localparam logic [19:0] OVH_LIMIT = 20'd65536;

  function automatic logic [1:0] phase_policy(input logic [2:0] ph, input int unsigned t);
    logic [1:0] m;
    m = AM_SHARED;
    case (ph)
      PH_LAUNCH, PH_ORBIT: m = (t == 0 || t == 1) ? AM_DEDICATED : AM_SHARED;
      PH_SCIENCE:          m = AM_HYBRID;
      PH_EMERGENCY:        m = AM_DEDICATED;
      default:             m = AM_SHARED;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/cha_div.sv
// Restoring serial divider, one quotient bit per cycle.
module cha_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cha_pkg::DIV_NW-1:0] dividend_i,
  input  logic [cha_pkg::DIV_DW-1:0] divisor_i,
  output logic                       done_o,
  output logic [cha_pkg::DIV_NW-1:0] quot_o
);
  import cha_pkg::*;

  localparam int CNTW = $clog2(DIV_NW);

  logic              busy_q, done_q;
  logic [CNTW-1:0]   cnt_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   rem_q;
  logic [DIV_DW-1:0] dvs_q;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> hdl/cha_win.sv
// Ratio window memory: one write port, one registered read port.
module cha_win #(
  parameter int DEPTH = 800,
  parameter int AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [cha_pkg::RATIO_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [cha_pkg::RATIO_W-1:0] rdata_o
);
  import cha_pkg::*;

  logic [RATIO_W-1:0] mem_q [DEPTH];
  logic [RATIO_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

>>> hdl/contention_hysteresis_mode_allocator.sv
// Allocation mode keeper: per-core contention windows, hysteresis mode switch.
//
// Usage:
//   Input beats arrive on s_axis_*: tuser carries the kind (report, evaluate,
//   set phase, force), tdata the core, wait and cycle counts, phase and mode.
//   Every input beat produces exactly one result beat on m_axis_*: the five
//   type modes, the changed mask, the mean contention over active cores and
//   the reporting core's windowed mean.
//   Configuration registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i
//   by the user only while the block is idle; the block itself does not enforce it.
// Sequencing:
//   One shared 48-bit serial divider (one quotient bit per cycle) does all
//   divisions, and a walk over the L active cores sums the means. A report
//   with nonzero elapsed time divides for its ratio and the core's mean, walks,
//   then divides for the overall mean; other beats only walk and divide, or
//   only walk when no active core has a ratio yet. One beat is in work at a
//   time; s_axis_tready is high only while the sequencer idles.
// Reset:
//   All modes go to shared, phase to cruise, windows empty, registers to
//   their defaults. No memory clearing pass is needed.
// Stall:
//   A result waits in the output register until taken; the next beat is
//   accepted meanwhile, and its result waits for the register to free.
module contention_hysteresis_mode_allocator #(
  parameter int MAX_CORES  = 8,
  parameter int WINDOW_LEN = 100,
  parameter int NUM_TYPES  = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // core[2:0], wait_cycles[34:3], now_cycle[66:35], phase[69:67], forced_mode[71:70]
  input  logic [cha_pkg::IN_DW-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // mode_matrix[1:0], mode_cordic[3:2], mode_compression[5:4], mode_image[7:6],
  // mode_fft[9:8], changed_mask[14:10], mean_contention[38:15],
  // core_contention[62:39], zero[63]
  output logic [cha_pkg::OUT_DW-1:0] m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [cha_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [cha_pkg::CFG_DW-1:0] cfg_wdata_i
);
  import cha_pkg::*;

  localparam int CW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int IW   = CW + 1;
  localparam int CNTW = $clog2(WINDOW_LEN + 1);
  localparam int HW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SW   = RATIO_W + CNTW;
  localparam int MSW  = RATIO_W + IW;
  localparam int DEPTH = MAX_CORES * WINDOW_LEN;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RGO   = 4'd1;
  localparam logic [3:0] S_RWAIT = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_CWAIT = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_MWAIT = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // configuration
  logic [3:0]         act_q;
  logic [RATIO_W-1:0] thr_q, mg_q;
  logic               adapt_q;
  logic [15:0]        ovh_q;

  // per-core state
  logic [CNTW-1:0]    cnt_q  [MAX_CORES];
  logic [HW-1:0]      head_q [MAX_CORES];
  logic [SW-1:0]      sum_q  [MAX_CORES];
  logic [RATIO_W-1:0] mean_q [MAX_CORES];
  logic [31:0]        last_q [MAX_CORES];

  logic [2:0]         phase_cur_q;
  logic [1:0]         mode_q [NUM_TYPES];

  // item registers
  logic [3:0]         st_q;
  logic [IW-1:0]      idx_q;
  logic [1:0]         kind_q;
  logic [31:0]        wait_q, el_q;
  logic [2:0]         ph_q;
  logic [1:0]         fm_q;
  logic [RATIO_W-1:0] ratio_q, core_out_q, avg_q;
  logic [MSW-1:0]     msum_q;
  logic [IW-1:0]      mn_q;
  logic [MAX_TYPES-1:0] mask_q;
  logic               m_valid_q;
  logic [OUT_DW-1:0]  m_data_q;
  logic               m_load;

  // divider
  logic              div_start;
  logic [DIV_NW-1:0] div_dvd, div_q;
  logic [DIV_DW-1:0] div_dvs;
  logic              div_done;

  // window memory
  logic              win_we;
  logic [AW-1:0]     win_addr;
  logic [RATIO_W-1:0] win_rd;

  logic [CW-1:0]     ci;
  logic [IW-1:0]     lim;
  logic              accept;
  logic [IW-1:0]     core_ext;
  logic              full;
  logic [RATIO_W-1:0] old_r;
  logic [SW-1:0]     new_sum;
  logic [CNTW-1:0]   new_cnt;
  logic [HW-1:0]     new_head;
  logic [31:0]       el_in;

  assign ci       = idx_q[CW-1:0];
  assign lim      = (32'(act_q) > 32'(MAX_CORES)) ? IW'(MAX_CORES) : IW'(act_q);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign core_ext = IW'(s_axis_tdata[2:0]);
  assign el_in    = s_axis_tdata[66:35] - last_q[core_ext[CW-1:0]];

  assign full     = 32'(cnt_q[ci]) >= 32'(WINDOW_LEN);
  assign old_r    = full ? win_rd : '0;
  assign new_sum  = sum_q[ci] - SW'(old_r) + SW'(ratio_q);
  assign new_cnt  = full ? cnt_q[ci] : cnt_q[ci] + 1'b1;
  assign new_head = (32'(head_q[ci]) + 32'd1 == 32'(WINDOW_LEN)) ? '0 : head_q[ci] + 1'b1;
  assign win_addr = AW'(32'(ci) * 32'(WINDOW_LEN) + 32'(head_q[ci]));
  assign win_we   = (st_q == S_UPD);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {wait_q, 16'd0};
    div_dvs   = el_q;
    case (st_q)
      S_RGO: begin
        div_start = 1'b1;
      end
      S_UPD: begin
        div_start = 1'b1;
        div_dvd   = DIV_NW'(new_sum);
        div_dvs   = DIV_DW'(new_cnt);
      end
      S_WALK: begin
        div_start = (idx_q >= lim) && (mn_q != '0);
        div_dvd   = DIV_NW'(msum_q);
        div_dvs   = DIV_DW'(mn_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cha_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  cha_win #(.DEPTH(DEPTH), .AW(AW)) u_win (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_addr),
    .wdata_i (ratio_q),
    .raddr_i (win_addr),
    .rdata_o (win_rd)
  );

  // mode update
  logic               ph_ok, ph_chg, do_eval, do_force;
  logic [2:0]         eval_ph;
  logic [RATIO_W:0]   thr_hi, avg_lo;
  logic               ovh_ok;
  logic [1:0]         nm [NUM_TYPES];
  logic [MAX_TYPES-1:0] mask_d;

  assign ph_ok   = ph_q <= PH_EMERGENCY;
  assign ph_chg  = (kind_q == KIND_PHASE) && ph_ok && (ph_q != phase_cur_q);
  assign eval_ph = ph_chg ? ph_q : phase_cur_q;
  assign do_eval = adapt_q && ((kind_q == KIND_EVAL) || ph_chg);
  assign do_force = (kind_q == KIND_FORCE) && (fm_q <= AM_HYBRID);
  assign thr_hi  = {1'b0, thr_q} + {1'b0, mg_q};
  assign avg_lo  = {1'b0, avg_q} + {1'b0, mg_q};
  assign ovh_ok  = (20'(ovh_q) * 20'd10) < OVH_LIMIT;

  always_comb begin
    mask_d = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      nm[t] = mode_q[t];
      if (do_force) begin
        nm[t] = fm_q;
      end else if (do_eval) begin
        if (eval_ph == PH_EMERGENCY || eval_ph == PH_LAUNCH) begin
          nm[t] = phase_policy(eval_ph, t);
        end else if ({1'b0, avg_q} > thr_hi) begin
          if (mode_q[t] == AM_SHARED) nm[t] = AM_DEDICATED;
        end else if (avg_lo < {1'b0, thr_q}) begin
          if (mode_q[t] == AM_DEDICATED && ovh_ok) nm[t] = AM_SHARED;
        end
      end
      mask_d[t] = nm[t] != mode_q[t];
    end
  end

  logic [2*MAX_TYPES-1:0] modes_flat;
  always_comb begin
    modes_flat = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      modes_flat[2*t +: 2] = mode_q[t];
    end
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_load        = (st_q == S_DONE) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 4'd8;
      thr_q       <= 24'd32768;
      mg_q        <= 24'd3277;
      adapt_q     <= 1'b1;
      ovh_q       <= 16'd13763;
      phase_cur_q <= PH_CRUISE;
      st_q        <= S_IDLE;
      m_valid_q   <= 1'b0;
      for (int c = 0; c < MAX_CORES; c++) begin
        cnt_q[c]  <= '0;
        head_q[c] <= '0;
        sum_q[c]  <= '0;
        mean_q[c] <= '0;
        last_q[c] <= '0;
      end
      for (int t = 0; t < NUM_TYPES; t++) begin
        mode_q[t] <= AM_SHARED;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ACTIVE:    act_q   <= cfg_wdata_i[3:0];
          REG_THRESHOLD: thr_q   <= cfg_wdata_i;
          REG_MARGIN:    mg_q    <= cfg_wdata_i;
          REG_ADAPTIVE:  adapt_q <= cfg_wdata_i[0];
          REG_OVERHEAD:  ovh_q   <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (st_q)
        S_IDLE: begin
          if (accept) begin
            kind_q     <= s_axis_tuser;
            wait_q     <= s_axis_tdata[34:3];
            ph_q       <= s_axis_tdata[69:67];
            fm_q       <= s_axis_tdata[71:70];
            el_q       <= el_in;
            msum_q     <= '0;
            mn_q       <= '0;
            if (s_axis_tuser == KIND_REPORT && core_ext < lim) begin
              last_q[core_ext[CW-1:0]] <= s_axis_tdata[66:35];
              if (el_in != '0) begin
                idx_q      <= core_ext;
                core_out_q <= '0;
                st_q       <= S_RGO;
              end else begin
                idx_q      <= '0;
                core_out_q <= mean_q[core_ext[CW-1:0]];
                st_q       <= S_WALK;
              end
            end else begin
              idx_q      <= '0;
              core_out_q <= '0;
              st_q       <= S_WALK;
            end
          end
        end
        S_RGO: begin
          st_q <= S_RWAIT;
        end
        S_RWAIT: begin
          if (div_done) begin
            ratio_q <= (div_q > DIV_NW'(RATIO_MAX)) ? RATIO_MAX : div_q[RATIO_W-1:0];
            st_q    <= S_RD;
          end
        end
        S_RD: begin
          // window read data lands next cycle
          st_q <= S_UPD;
        end
        S_UPD: begin
          sum_q[ci]  <= new_sum;
          cnt_q[ci]  <= new_cnt;
          head_q[ci] <= new_head;
          st_q       <= S_CWAIT;
        end
        S_CWAIT: begin
          if (div_done) begin
            mean_q[ci] <= div_q[RATIO_W-1:0];
            core_out_q <= div_q[RATIO_W-1:0];
            idx_q      <= '0;
            st_q       <= S_WALK;
          end
        end
        S_WALK: begin
          if (idx_q < lim) begin
            if (cnt_q[ci] != '0) begin
              msum_q <= msum_q + MSW'(mean_q[ci]);
              mn_q   <= mn_q + 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end else if (mn_q != '0) begin
            st_q <= S_MWAIT;
          end else begin
            avg_q <= '0;
            st_q  <= S_APPLY;
          end
        end
        S_MWAIT: begin
          if (div_done) begin
            avg_q <= div_q[RATIO_W-1:0];
            st_q  <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (ph_chg) phase_cur_q <= ph_q;
          for (int t = 0; t < NUM_TYPES; t++) begin
            mode_q[t] <= nm[t];
          end
          mask_q <= mask_d;
          st_q   <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (m_load) begin
            m_data_q  <= {1'b0, core_out_q, avg_q, mask_q, modes_flat};
            st_q      <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  // busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("accepted a beat while still working");

  // a report never changes a mode
  a_report_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[62:39] != '0) |-> (m_axis_tdata[14:10] == '0))
    else $error("report result carries a mode change");

  // no mode takes the unused code
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[3:2] != 2'd3) &&
                      (m_axis_tdata[5:4] != 2'd3) && (m_axis_tdata[7:6] != 2'd3) &&
                      (m_axis_tdata[9:8] != 2'd3))
    else $error("illegal mode code on output");

  // result loads only from the final sequencer state
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q) == S_DONE)
    else $error("result appeared outside the final step");

endmodule
